>>> hw/rtl/lzwd_pkg.sv
// Package for the LZW code decompressor.
// Holds the transaction payload types, the control codes and the status codes.
// Also holds the register indices and FIRST_CODE_RESET. Depends on nothing.
package lzwd_pkg;

	typedef struct packed {
		logic [11:0] code_word;
		logic        stream_end;
	} in_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
		logic [2:0] status;
	} out_t;

	localparam logic [11:0] CODE_CLEAR = 12'd256;
	localparam logic [11:0] CODE_EOR   = 12'd259;
	localparam logic [11:0] CODE_ETX   = 12'd260;

	localparam logic [2:0] ST_DATA     = 3'd0;
	localparam logic [2:0] ST_EOR      = 3'd1;
	localparam logic [2:0] ST_ETX      = 3'd2;
	localparam logic [2:0] ST_EOF      = 3'd3;
	localparam logic [2:0] ST_MARKER   = 3'd4;
	localparam logic [2:0] ST_BAD_CTRL = 3'd5;
	localparam logic [2:0] ST_OVERFLOW = 3'd6;

	localparam logic [1:0] REG_DELTA    = 2'd0;
	localparam logic [1:0] REG_END_MARK = 2'd1;
	localparam logic [1:0] REG_MAX_BITS = 2'd2;
	localparam logic [1:0] REG_FIRST    = 2'd3;

	localparam logic [12:0] FIRST_CODE_RESET = 13'd261;

endpackage

>>> hw/rtl/lzw_code_decompressor_core.sv
// Top level of the LZW code decompressor: one code in, the decoded bytes or a status result out.
// From one accepted code to the next without output stalls: a decode step, one dictionary read and
// one stack write per dictionary link, a stack write for the literal, a stack read and an output
// step per byte, and an idle step; a new code is taken only when idle. A status or a first code's
// byte: decode, emit, idle (an overflow walks first); a CLEAR: decode, idle; output stalls add.
// Reset clears control state only; the dictionary and the stack need no clearing.
// Depends on lzwd_pkg.
module lzw_code_decompressor_core #(
	parameter int TABLE_BITS  = 12,
	parameter int STACK_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lzwd_pkg::in_t       in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output lzwd_pkg::out_t      out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [8:0]          cfg_data
);
	import lzwd_pkg::*;

	localparam int TW = TABLE_BITS;
	localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int NW = $clog2(STACK_DEPTH + 1);
	localparam logic [NW-1:0] DEPTH_N = NW'(STACK_DEPTH);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_WALK   = 3'd2;
	localparam logic [2:0] S_LINK   = 3'd3;
	localparam logic [2:0] S_POPRD  = 3'd4;
	localparam logic [2:0] S_POPOUT = 3'd5;
	localparam logic [2:0] S_EMIT1  = 3'd6;

	localparam logic [1:0] PH_FIRST   = 2'd0;
	localparam logic [1:0] PH_NORMAL  = 2'd1;
	localparam logic [1:0] PH_CLEARED = 2'd2;

	logic [2:0]    state_q;
	logic [1:0]    phase_q;
	logic          delta_q, endmark_q;
	logic [3:0]    maxbits_q;
	logic [8:0]    first_code_q;
	logic [12:0]   nfc_q;
	logic [11:0]   prev_code_q;
	logic [7:0]    pfb_q;
	logic [7:0]    sum_q;
	logic [11:0]   code_q;
	logic          end_q;
	logic [11:0]   cur_q;
	logic [NW-1:0] n_q;
	out_t          res_q;
	out_t          out_q;
	logic          out_valid_q;

	logic [19:0]   dict_mem [0:(1 << TW)-1];
	logic [19:0]   dict_rd_q;
	logic [7:0]    stk_mem [0:STACK_DEPTH-1];
	logic [7:0]    stk_rd_q;

	logic          out_free;
	logic [12:0]   nfc_eff;
	logic          kwk;
	logic          is_ctrl;
	logic          dict_we, dict_re;
	logic [TW-1:0] dict_wa;
	logic [19:0]   dict_wd;
	logic          stk_we, stk_re;
	logic [SW-1:0] stk_wa;
	logic [7:0]    stk_wd;
	logic [3:0]    limit_bits;
	logic          room;
	logic [7:0]    walk_byte;
	logic [7:0]    pop_byte;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign nfc_eff = (phase_q == PH_CLEARED) ? (nfc_q - 13'd1) : nfc_q;
	assign kwk     = ({1'b0, code_q} >= nfc_eff);
	assign is_ctrl = (code_q >= CODE_CLEAR) && (code_q < {3'b000, first_code_q});

	assign limit_bits = (32'(maxbits_q) > TABLE_BITS) ? 4'(TABLE_BITS) : maxbits_q;
	assign room       = ((nfc_q >> limit_bits) == 13'd0);
	assign walk_byte  = cur_q[7:0];
	assign pop_byte   = delta_q ? (sum_q + stk_rd_q) : stk_rd_q;

	always_comb begin
		dict_we = 1'b0;
		dict_re = 1'b0;
		dict_wa = TW'(nfc_q);
		dict_wd = {prev_code_q, walk_byte};
		stk_we  = 1'b0;
		stk_re  = 1'b0;
		stk_wa  = n_q[SW-1:0];
		stk_wd  = walk_byte;
		case (state_q)
			S_DECODE: begin
				if (!end_q && phase_q != PH_FIRST && !is_ctrl && kwk &&
				    !(phase_q == PH_CLEARED && endmark_q && code_q == CODE_CLEAR)) begin
					stk_we = 1'b1;
					stk_wa = '0;
					stk_wd = pfb_q;
				end
			end
			S_WALK: begin
				if (n_q < DEPTH_N) begin
					if (cur_q < 12'd256) begin
						stk_we  = 1'b1;
						dict_we = room;
					end else begin
						dict_re = 1'b1;
					end
				end
			end
			S_LINK: begin
				stk_we = 1'b1;
				stk_wd = dict_rd_q[7:0];
			end
			S_POPRD: begin
				stk_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dict_we) begin
			dict_mem[dict_wa] <= dict_wd;
		end
		if (dict_re) begin
			dict_rd_q <= dict_mem[TW'(cur_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[SW'(n_q - NW'(1))];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_FIRST;
			delta_q      <= 1'b0;
			endmark_q    <= 1'b0;
			maxbits_q    <= 4'd12;
			first_code_q <= FIRST_CODE_RESET[8:0];
			nfc_q        <= FIRST_CODE_RESET;
			prev_code_q  <= '0;
			pfb_q        <= '0;
			sum_q        <= '0;
			out_valid_q  <= 1'b0;
			n_q          <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_DELTA:    delta_q      <= cfg_data[0];
					REG_END_MARK: endmark_q    <= cfg_data[0];
					REG_MAX_BITS: maxbits_q    <= cfg_data[3:0];
					REG_FIRST:    first_code_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					res_q   <= '{data_byte: 8'd0, byte_valid: 1'b0, last: 1'b1,
					             status: ST_DATA};
					state_q <= S_EMIT1;
					if (end_q) begin
						res_q.status <= ST_EOF;
						phase_q      <= PH_FIRST;
					end else if (phase_q == PH_FIRST) begin
						res_q.data_byte  <= code_q[7:0];
						res_q.byte_valid <= 1'b1;
						sum_q            <= code_q[7:0];
						pfb_q            <= code_q[7:0];
						prev_code_q      <= code_q;
						phase_q          <= PH_NORMAL;
					end else if (phase_q == PH_CLEARED && endmark_q &&
					             code_q == CODE_CLEAR) begin
						res_q.status <= ST_MARKER;
						phase_q      <= PH_FIRST;
					end else begin
						nfc_q   <= nfc_eff;
						phase_q <= PH_NORMAL;
						if (is_ctrl) begin
							case (code_q)
								CODE_CLEAR: begin
									nfc_q   <= {4'd0, first_code_q};
									phase_q <= PH_CLEARED;
									state_q <= S_IDLE;
								end
								CODE_EOR: begin
									res_q.status <= ST_EOR;
									phase_q      <= PH_FIRST;
								end
								CODE_ETX: begin
									res_q.status <= ST_ETX;
									phase_q      <= PH_FIRST;
								end
								default: begin
									res_q.status <= ST_BAD_CTRL;
									phase_q      <= PH_FIRST;
								end
							endcase
						end else begin
							cur_q   <= kwk ? prev_code_q : code_q;
							n_q     <= kwk ? NW'(1) : '0;
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (n_q >= DEPTH_N) begin
						res_q   <= '{data_byte: 8'd0, byte_valid: 1'b0, last: 1'b1,
						             status: ST_OVERFLOW};
						phase_q <= PH_FIRST;
						state_q <= S_EMIT1;
					end else if (cur_q < 12'd256) begin
						n_q         <= n_q + NW'(1);
						prev_code_q <= code_q;
						pfb_q       <= walk_byte;
						if (room) begin
							nfc_q <= nfc_q + 13'd1;
						end
						state_q <= S_POPRD;
					end else begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					n_q     <= n_q + NW'(1);
					cur_q   <= dict_rd_q[19:8];
					state_q <= S_WALK;
				end
				S_POPRD: begin
					state_q <= S_POPOUT;
				end
				S_POPOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= '{data_byte: pop_byte, byte_valid: 1'b1,
						                 last: (n_q == NW'(1)), status: ST_DATA};
						if (delta_q) begin
							sum_q <= pop_byte;
						end
						n_q     <= n_q - NW'(1);
						state_q <= (n_q == NW'(1)) ? S_IDLE : S_POPRD;
					end
				end
				S_EMIT1: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			code_q <= in_data.code_word;
			end_q  <= in_data.stream_end;
		end
	end

endmodule
